// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/drae_pkg.sv =====
package drae_pkg;

   // Final status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ID      = 3'd1,
      ST_RCODE   = 3'd2,
      ST_NOMATCH = 3'd3,
      ST_TRUNC   = 3'd4
   } drae_status_type;

   // Result item kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One result item
   typedef struct packed {
      logic            kind;
      logic [7:0]      answer_byte;
      drae_status_type status;
      logic [3:0]      server_rcode;
      logic [15:0]     answer_length;
   } drae_result_type;

   // Up to two results produced by one consumed byte, in order
   typedef struct packed {
      logic            first_vld;
      logic            second_vld;
      drae_result_type first;
      drae_result_type second;
   } drae_push_type;

endpackage

// ===== design/drae_parser.sv =====
`include "assert_macros.svh"

module drae_parser
   import drae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  logic          consume,
   input  logic [7:0]    data_byte,
   input  logic          end_of_packet,
   output drae_push_type push
);

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QLABEL = 4'd2,
      PH_QPTR   = 4'd3,
      PH_QFIXED = 4'd4,
      PH_ANAME  = 4'd5,
      PH_ALABEL = 4'd6,
      PH_APTR   = 4'd7,
      PH_AFIXED = 4'd8,
      PH_SKIP   = 4'd9,
      PH_EMIT   = 4'd10
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] shift_ff, shift_in;
   logic [7:0]  label_ff, label_in;
   logic [15:0] answers_ff, answers_in;
   logic [15:0] wtype_ff, wtype_in;
   logic [15:0] wclass_ff, wclass_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rclass_ff, rclass_in;
   logic [15:0] rdata_ff, rdata_in;
   logic        finished_ff, finished_in;
   logic [15:0] expected_id_ff;

   logic            data_vld;
   logic            st_vld;
   drae_status_type st_code;
   logic [3:0]      st_rcode;
   logic [15:0]     st_len;
   drae_result_type data_item;
   drae_result_type st_item;

   // Per-byte parse step
   always_comb begin
      logic [15:0] shifted;
      logic [3:0]  cnt_inc;
      logic [15:0] ans_dec;
      logic [15:0] rd_dec;
      logic [7:0]  lab_dec;
      logic        is_q;

      shifted  = {shift_ff[7:0], data_byte};
      cnt_inc  = count_ff + 4'd1;
      ans_dec  = answers_ff - 16'd1;
      rd_dec   = rdata_ff - 16'd1;
      lab_dec  = label_ff - 8'd1;
      is_q     = (phase_ff == PH_QNAME) || (phase_ff == PH_QLABEL) || (phase_ff == PH_QPTR);

      phase_in   = phase_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      label_in   = label_ff;
      answers_in = answers_ff;
      wtype_in   = wtype_ff;
      wclass_in  = wclass_ff;
      rtype_in   = rtype_ff;
      rclass_in  = rclass_ff;
      rdata_in   = rdata_ff;
      data_vld   = 1'b0;
      st_vld     = 1'b0;
      st_code    = ST_OK;
      st_rcode   = 4'd0;
      st_len     = 16'd0;

      if (!finished_ff) begin
         unique case (phase_ff) inside
            PH_HEADER: begin
               shift_in = shifted;
               count_in = cnt_inc;
               if (cnt_inc == 4'd2 && shifted != expected_id_ff) begin
                  st_vld  = 1'b1;
                  st_code = ST_ID;
               end else if (cnt_inc == 4'd4 && shifted[3:0] != 4'd0) begin
                  st_vld   = 1'b1;
                  st_code  = ST_RCODE;
                  st_rcode = shifted[3:0];
               end else if (cnt_inc == 4'd8) begin
                  answers_in = shifted;
               end else if (cnt_inc == 4'd12) begin
                  phase_in = PH_QNAME;
                  count_in = 4'd0;
               end
            end
            PH_QNAME, PH_ANAME: begin
               // zero ends the name, top bits set start a pointer
               if (data_byte == 8'd0) begin
                  phase_in = is_q ? PH_QFIXED : PH_AFIXED;
                  count_in = 4'd0;
               end else if (data_byte[7:6] == 2'b11) begin
                  phase_in = is_q ? PH_QPTR : PH_APTR;
               end else begin
                  label_in = data_byte;
                  phase_in = is_q ? PH_QLABEL : PH_ALABEL;
               end
            end
            PH_QLABEL, PH_ALABEL: begin
               label_in = lab_dec;
               if (lab_dec == 8'd0) phase_in = is_q ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR, PH_APTR: begin
               phase_in = is_q ? PH_QFIXED : PH_AFIXED;
               count_in = 4'd0;
            end
            PH_QFIXED: begin
               shift_in = shifted;
               count_in = cnt_inc;
               if (cnt_inc == 4'd2) begin
                  wtype_in = shifted;
               end else if (cnt_inc == 4'd4) begin
                  wclass_in = shifted;
                  if (answers_ff == 16'd0) begin
                     st_vld  = 1'b1;
                     st_code = ST_NOMATCH;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end
            end
            PH_AFIXED: begin
               shift_in = shifted;
               count_in = cnt_inc;
               if (cnt_inc == 4'd2) begin
                  rtype_in = shifted;
               end else if (cnt_inc == 4'd4) begin
                  rclass_in = shifted;
               end else if (cnt_inc == 4'd10) begin
                  rdata_in = shifted;
                  if (rtype_ff == wtype_ff && rclass_ff == wclass_ff) begin
                     if (shifted == 16'd0) begin
                        st_vld  = 1'b1;
                        st_code = ST_OK;
                     end else begin
                        phase_in = PH_EMIT;
                     end
                  end else if (shifted == 16'd0) begin
                     // empty record: move on to the next one
                     answers_in = ans_dec;
                     if (ans_dec == 16'd0) begin
                        st_vld  = 1'b1;
                        st_code = ST_NOMATCH;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               rdata_in = rd_dec;
               if (rd_dec == 16'd0) begin
                  answers_in = ans_dec;
                  if (ans_dec == 16'd0) begin
                     st_vld  = 1'b1;
                     st_code = ST_NOMATCH;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end
            end
            PH_EMIT: begin
               data_vld = 1'b1;
               rdata_in = rd_dec;
               if (rd_dec == 16'd0) begin
                  st_vld  = 1'b1;
                  st_code = ST_OK;
                  st_len  = shift_ff;
               end
            end
            default: ;
         endcase
      end

      finished_in = finished_ff || st_vld;

      // packet end raises truncation if no final status came, then back to the header phase
      if (end_of_packet) begin
         if (!finished_in) begin
            st_vld  = 1'b1;
            st_code = ST_TRUNC;
         end
         phase_in    = PH_HEADER;
         count_in    = 4'd0;
         shift_in    = 16'd0;
         label_in    = 8'd0;
         answers_in  = 16'd0;
         wtype_in    = 16'd0;
         wclass_in   = 16'd0;
         rtype_in    = 16'd0;
         rclass_in   = 16'd0;
         rdata_in    = 16'd0;
         finished_in = 1'b0;
      end
   end

   // Result items
   always_comb begin
      data_item.kind          = KIND_DATA;
      data_item.answer_byte   = data_byte;
      data_item.status        = ST_OK;
      data_item.server_rcode  = 4'd0;
      data_item.answer_length = shift_ff;

      st_item.kind            = KIND_STATUS;
      st_item.answer_byte     = 8'd0;
      st_item.status          = st_code;
      st_item.server_rcode    = st_rcode;
      st_item.answer_length   = st_len;

      push.first_vld  = consume && (data_vld || st_vld);
      push.second_vld = consume && data_vld && st_vld;
      push.first      = data_vld ? data_item : st_item;
      push.second     = st_item;
   end

   // Parse state and identifier register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         count_ff       <= 4'd0;
         shift_ff       <= 16'd0;
         label_ff       <= 8'd0;
         answers_ff     <= 16'd0;
         wtype_ff       <= 16'd0;
         wclass_ff      <= 16'd0;
         rtype_ff       <= 16'd0;
         rclass_ff      <= 16'd0;
         rdata_ff       <= 16'd0;
         finished_ff    <= 1'b0;
         expected_id_ff <= 16'd0;
      end else begin
         if (csr_wr_en) expected_id_ff <= csr_wr_data;
         if (consume) begin
            phase_ff    <= phase_in;
            count_ff    <= count_in;
            shift_ff    <= shift_in;
            label_ff    <= label_in;
            answers_ff  <= answers_in;
            wtype_ff    <= wtype_in;
            wclass_ff   <= wclass_in;
            rtype_ff    <= rtype_in;
            rclass_ff   <= rclass_in;
            rdata_ff    <= rdata_in;
            finished_ff <= finished_in;
         end
      end
   end

   `ASSERT_NEVER(a_quiet_when_done, clock, reset, finished_ff && push.first_vld, "result after final status")
   `ASSERT_CLK(a_pair_order, clock, reset, push.second_vld |-> (push.first_vld && push.first.kind == KIND_DATA && push.second.kind == KIND_STATUS), "bad result pair")
   `ASSERT_CLK(a_eop_clears, clock, reset, (consume && end_of_packet) |=> (phase_ff == PH_HEADER && !finished_ff), "packet end did not clear state")

endmodule

// ===== design/drae_out_queue.sv =====
`include "assert_macros.svh"

module drae_out_queue
   import drae_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  drae_push_type   push,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output drae_result_type out_item
);

   drae_result_type entries [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [1:0]        push_n;
   logic              pop;

   // Room for a full pair of results, judged before this cycle's pop
   assign room      = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = entries[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign push_n    = {1'b0, push.first_vld} + {1'b0, push.second_vld};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.first_vld) entries[wr_ptr_ff] <= push.first;
      if (push.second_vld) entries[wr_ptr_ff + QPTR_W'(1)] <= push.second;
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, count_ff > QCNT_W'(QUEUE_DEPTH), "result queue overflow")
   `ASSERT_NEVER(a_push_needs_room, clock, reset, push.first_vld && !room, "push without room")
   `ASSERT_CLK(a_level_tracks, clock, reset, (!push.first_vld && pop) |=> (count_ff == $past(count_ff) - QCNT_W'(1)), "fill level lost a pop")

endmodule

// ===== design/dns_response_answer_extractor_unit.sv =====
// DNS response answer extractor.
// req_*: one message byte per transfer in wire order, tlast on the final byte.
// rsp_*: result items; tuser 0 is an RDATA byte of the first answer record
//   whose type and class match the question, tuser 1 (with tlast) is the
//   final status of the packet. A byte gives zero, one or two results.
// csr_*: write of the expected transaction ID; write it only while idle, the block does not enforce this.
// A byte taken into the input register is parsed from there when the queue
//   has room, and its results are written into the result queue.
// Throughput: one byte per cycle while the queue has room, set by the
//   combinational parse step between the input register and a four-entry result
//   queue; a byte is parsed only when two queue entries are free, and a byte
//   with two results leaves the queue as two transfers.
// Reset clears the parse state, the ID register, the input register and the
//   queue. When the receiver stalls the queue fills and req_tready drops
//   after the input register is occupied; nothing is lost.
module dns_response_answer_extractor_unit
   import drae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] answer_byte, [10:8] status,
                                    // [14:11] server_rcode, [30:15] answer_length
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            in_eop_ff;
   logic            room;
   logic            consume;
   logic            take;
   drae_push_type   push;
   drae_result_type out_item;

   // Input register
   assign consume    = in_vld_ff && room;
   assign req_tready = !in_vld_ff || consume;
   assign take       = req_tvalid && req_tready;
   assign in_vld_in  = take || (in_vld_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_tdata;
         in_eop_ff  <= req_tlast;
      end
   end

   drae_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .consume       (consume),
      .data_byte     (in_byte_ff),
      .end_of_packet (in_eop_ff),
      .push          (push)
   );

   drae_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Result packing
   assign rsp_tdata = {1'b0, out_item.answer_length, out_item.server_rcode,
                       out_item.status, out_item.answer_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.kind;

endmodule

// ===== bench/dns_response_answer_extractor_unit_tb.sv =====
`timescale 1ns / 1ps

module dns_response_answer_extractor_unit_tb;
   import drae_pkg::*;

   // Parse phases of the response walk
   typedef enum logic [3:0] {
      PH_HEADER, PH_QNAME, PH_QLABEL, PH_QPTR, PH_QFIXED,
      PH_ANAME, PH_ALABEL, PH_APTR, PH_AFIXED, PH_SKIP, PH_EMIT
   } walk_phase_type;

   // One expected result item
   typedef struct packed {
      logic            kind;
      logic [7:0]      data;
      drae_status_type status;
      logic [3:0]      rcode;
      logic [15:0]     ans_len;
      logic            last;
   } answer_item_type;

   // Mirror of the extractor: walks each byte and queues the results it must produce
   class answer_extractor_mirror;
      logic [15:0]     expected_id;
      walk_phase_type  phase;
      logic [15:0]     byte_cnt;
      logic [15:0]     shift_word;
      logic [7:0]      label_left;
      logic [15:0]     answers_left;
      logic [15:0]     wanted_type;
      logic [15:0]     wanted_class;
      logic [15:0]     rec_type;
      logic [15:0]     rec_class;
      logic [15:0]     rdata_left;
      logic            done;
      answer_item_type pending_answers[$];
      int              errors;

      function new();
         expected_id = '0;
         errors      = 0;
         restart();
      endfunction

      function void restart();
         phase        = PH_HEADER;
         byte_cnt     = '0;
         shift_word   = '0;
         label_left   = '0;
         answers_left = '0;
         wanted_type  = '0;
         wanted_class = '0;
         rec_type     = '0;
         rec_class    = '0;
         rdata_left   = '0;
         done         = 1'b0;
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      function void add_item(logic kind, logic [7:0] data, drae_status_type status,
                             logic [3:0] rcode, logic [15:0] ans_len);
         answer_item_type item;
         item.kind    = kind;
         item.data    = data;
         item.status  = status;
         item.rcode   = rcode;
         item.ans_len = ans_len;
         item.last    = kind;
         pending_answers.push_back(item);
      endfunction

      function void close_packet(drae_status_type status, logic [3:0] rcode,
                                 logic [15:0] ans_len);
         add_item(KIND_STATUS, 8'h00, status, rcode, ans_len);
         done = 1'b1;
      endfunction

      // Name byte: zero ends the name, 11xxxxxx opens a two-byte pointer, else a label
      function void name_byte(logic [7:0] b, walk_phase_type label_ph,
                              walk_phase_type ptr_ph, walk_phase_type fixed_ph);
         if (b == 8'h00) begin
            phase    = fixed_ph;
            byte_cnt = '0;
         end else if (b[7:6] == 2'b11) begin
            phase = ptr_ph;
         end else begin
            label_left = b;
            phase      = label_ph;
         end
      endfunction

      function void record_end();
         answers_left = answers_left - 16'd1;
         if (answers_left == 16'd0)
            close_packet(ST_NOMATCH, 4'h0, 16'h0000);
         else
            phase = PH_ANAME;
      endfunction

      function void take_byte(logic [7:0] b, logic eop);
         if (done) begin
            if (eop)
               restart();
            return;
         end
         case (phase)
            PH_HEADER: begin
               shift_word = {shift_word[7:0], b};
               byte_cnt   = byte_cnt + 16'd1;
               if (byte_cnt == 16'd2 && shift_word != expected_id)
                  close_packet(ST_ID, 4'h0, 16'h0000);
               else if (byte_cnt == 16'd4 && shift_word[3:0] != 4'h0)
                  close_packet(ST_RCODE, shift_word[3:0], 16'h0000);
               else if (byte_cnt == 16'd8)
                  answers_left = shift_word;
               else if (byte_cnt == 16'd12) begin
                  phase    = PH_QNAME;
                  byte_cnt = '0;
               end
            end
            PH_QNAME: name_byte(b, PH_QLABEL, PH_QPTR, PH_QFIXED);
            PH_ANAME: name_byte(b, PH_ALABEL, PH_APTR, PH_AFIXED);
            PH_QLABEL, PH_ALABEL: begin
               label_left = label_left - 8'd1;
               if (label_left == 8'd0)
                  phase = (phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR, PH_APTR: begin
               phase    = (phase == PH_QPTR) ? PH_QFIXED : PH_AFIXED;
               byte_cnt = '0;
            end
            PH_QFIXED: begin
               shift_word = {shift_word[7:0], b};
               byte_cnt   = byte_cnt + 16'd1;
               if (byte_cnt == 16'd2)
                  wanted_type = shift_word;
               else if (byte_cnt == 16'd4) begin
                  wanted_class = shift_word;
                  if (answers_left == 16'd0)
                     close_packet(ST_NOMATCH, 4'h0, 16'h0000);
                  else
                     phase = PH_ANAME;
               end
            end
            PH_AFIXED: begin
               shift_word = {shift_word[7:0], b};
               byte_cnt   = byte_cnt + 16'd1;
               if (byte_cnt == 16'd2)
                  rec_type = shift_word;
               else if (byte_cnt == 16'd4)
                  rec_class = shift_word;
               else if (byte_cnt == 16'd10) begin
                  rdata_left = shift_word;
                  if (rec_type == wanted_type && rec_class == wanted_class) begin
                     if (rdata_left == 16'd0)
                        close_packet(ST_OK, 4'h0, 16'h0000);
                     else
                        phase = PH_EMIT;
                  end else if (rdata_left == 16'd0) begin
                     record_end();
                  end else begin
                     phase = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               rdata_left = rdata_left - 16'd1;
               if (rdata_left == 16'd0)
                  record_end();
            end
            PH_EMIT: begin
               // shift_word still holds the RDATA length here
               add_item(KIND_DATA, b, ST_OK, 4'h0, shift_word);
               rdata_left = rdata_left - 16'd1;
               if (rdata_left == 16'd0)
                  close_packet(ST_OK, 4'h0, shift_word);
            end
            default: ;
         endcase
         // packet end raises truncation if cut short before a final status, then restart
         if (eop) begin
            if (!done)
               close_packet(ST_TRUNC, 4'h0, 16'h0000);
            restart();
         end
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("%0t: %s", $time, msg);
      endfunction

      function void match_result(logic kind, logic [31:0] tdata, logic last);
         answer_item_type want;
         if (pending_answers.size() == 0) begin
            flag($sformatf("unexpected result: kind %0d tdata %h last %0d",
                           kind, tdata, last));
            return;
         end
         want = pending_answers.pop_front();
         if (kind !== want.kind || tdata[7:0] !== want.data ||
             tdata[10:8] !== want.status || tdata[14:11] !== want.rcode ||
             tdata[30:15] !== want.ans_len || last !== want.last)
            flag($sformatf({"result mismatch: expected kind %0d byte %h status %0d ",
                            "rcode %0d len %0d last %0d, got kind %0d byte %h ",
                            "status %0d rcode %0d len %0d last %0d"},
                           want.kind, want.data, want.status, want.rcode,
                           want.ans_len, want.last, kind, tdata[7:0], tdata[10:8],
                           tdata[14:11], tdata[30:15], last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   answer_extractor_mirror mirror;
   logic [7:0]  pkt_q[$];
   logic [15:0] cur_id;
   logic        gaps_on;
   logic        stalls_on;
   int          bytes_sent;
   int          ready_left;

   dns_response_answer_extractor_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Result side: check every transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.match_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Receiver back-pressure in bursts
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_tready <= 1'b1;
         ready_left <= 0;
      end else if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else if (rsp_tready && $urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         ready_left <= $urandom_range(1, 16) - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_left <= $urandom_range(1, 16) - 1;
      end
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("dns_response_answer_extractor_unit_tb: done, errors");
      $finish;
   end

   function void put_byte(logic [7:0] b);
      pkt_q.push_back(b);
   endfunction

   function void put_word(logic [15:0] w);
      pkt_q.push_back(w[15:8]);
      pkt_q.push_back(w[7:0]);
   endfunction

   function void put_header(logic [15:0] id, logic [15:0] flags, logic [15:0] an_cnt);
      put_word(id);
      put_word(flags);
      put_word(16'd1);
      put_word(an_cnt);
      put_word(16'd0);
      put_word(16'd0);
   endfunction

   function void put_random(int count);
      repeat (count) put_byte(8'($urandom_range(0, 255)));
   endfunction

   // Labels of mixed length, ended by a root byte or a compression pointer
   function void put_name();
      int n_lab;
      int len;
      int r;
      n_lab = $urandom_range(0, 3);
      repeat (n_lab) begin
         r   = $urandom_range(0, 29);
         len = (r == 0) ? $urandom_range(64, 191) : (r < 3) ? 63 : $urandom_range(1, 6);
         put_byte(8'(len));
         put_random(len);
      end
      if ($urandom_range(0, 2) == 0) begin
         put_byte(8'hc0 | 8'($urandom_range(0, 63)));
         put_random(1);
      end else begin
         put_byte(8'h00);
      end
   endfunction

   function logic [15:0] pick_code();
      logic [15:0] code;
      code = 16'($urandom);
      case ($urandom_range(0, 5))
         0: code = 16'd1;
         1: code = 16'd28;
         2: code = 16'd5;
         3: code = 16'd255;
         default: ;
      endcase
      return code;
   endfunction

   // One response: mostly well formed with random content, some noise and early ends
   function void build_response();
      int          an_cnt;
      int          n_rec;
      int          hit;
      int          i;
      int          cut;
      logic [15:0] w;
      logic [15:0] qt;
      logic [15:0] qc;
      logic [15:0] rt;
      logic [15:0] rc;
      logic [15:0] rdl;
      pkt_q.delete();
      if ($urandom_range(0, 99) < 8) begin
         put_random($urandom_range(1, 40));
         return;
      end
      w = 16'($urandom);
      put_word(($urandom_range(0, 9) == 0) ? w : cur_id);
      w = 16'($urandom);
      if ($urandom_range(0, 9) != 0)
         w[3:0] = 4'h0;
      put_word(w);
      put_random(2);
      case ($urandom_range(0, 19))
         0: an_cnt = 0;
         1: an_cnt = $urandom_range(5, 65535);
         default: an_cnt = $urandom_range(1, 4);
      endcase
      put_word(16'(an_cnt));
      put_random(4);
      put_name();
      qt = pick_code();
      qc = ($urandom_range(0, 1) == 0) ? 16'd1 : pick_code();
      put_word(qt);
      put_word(qc);
      n_rec = (an_cnt > 4) ? $urandom_range(1, 4) : an_cnt;
      hit   = $urandom_range(0, n_rec);
      for (i = 0; i < n_rec; i++) begin
         if ($urandom_range(0, 9) < 7)
            put_word(16'hc00c);
         else
            put_name();
         rt = qt;
         rc = qc;
         if (i != hit) begin
            case ($urandom_range(0, 2))
               0: rt = qt ^ (16'h0001 << $urandom_range(0, 15));
               1: rc = qc ^ (16'h0001 << $urandom_range(0, 15));
               default: begin
                  rt = 16'($urandom);
                  rc = 16'($urandom);
                  if (rt == qt && rc == qc)
                     rt = ~qt;
               end
            endcase
         end
         put_word(rt);
         put_word(rc);
         put_random(4);
         // long RDATA length, the packet ends well before it
         if ($urandom_range(0, 11) == 0) begin
            rdl = 16'($urandom_range(7, 65535));
            put_word(rdl);
            put_random($urandom_range(0, 5));
            return;
         end
         rdl = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         put_word(rdl);
         put_random(int'(rdl));
      end
      put_random($urandom_range(0, 3));
      if ($urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, pkt_q.size());
         while (pkt_q.size() > cut)
            void'(pkt_q.pop_back());
      end
   endfunction

   // Send pkt_q, tlast on its final byte; waits for the result side at hold_at
   task automatic send_packet(input int hold_at);
      int i;
      for (i = 0; i < pkt_q.size(); i++) begin
         if (i == hold_at) begin
            req_tvalid = 1'b0;
            while (mirror.pending() != 0)
               @(negedge clock);
         end
         if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         req_tdata  = pkt_q[i];
         req_tlast  = (i == pkt_q.size() - 1);
         req_tvalid = 1'b1;
         @(posedge clock);
         while (!req_tready)
            @(posedge clock);
         mirror.take_byte(pkt_q[i], req_tlast);
         bytes_sent++;
         @(negedge clock);
      end
   endtask

   // Let every expected result arrive, then idle so that any unexpected result shows up
   task automatic drain_block();
      req_tvalid = 1'b0;
      while (mirror.pending() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_expected_id(input logic [15:0] id_val);
      csr_wr_en   = 1'b1;
      csr_wr_data = id_val;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      mirror.expected_id = id_val;
      cur_id             = id_val;
   endtask

   task automatic run_random(input int budget, input logic idling, input logic hold_once);
      int start;
      logic held;
      start = bytes_sent;
      held  = 1'b0;
      while (bytes_sent - start < budget) begin
         build_response();
         gaps_on   = idling && ($urandom_range(0, 3) != 0);
         stalls_on = idling && ($urandom_range(0, 3) != 0);
         if (hold_once && !held && bytes_sent - start > budget / 2 && pkt_q.size() > 4) begin
            send_packet(pkt_q.size() / 2);
            held = 1'b1;
         end else begin
            send_packet(-1);
         end
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      ready_left  = 0;
      gaps_on     = 1'b0;
      stalls_on   = 1'b0;
      bytes_sent  = 0;
      cur_id      = '0;
      mirror      = new();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed responses against the reset ID of zero
      // wrong ID, all-ones ID bytes; the rest is ignored
      pkt_q.delete();
      put_word(16'hffff);
      put_word(16'h007f);
      send_packet(-1);
      // server error, rcode 15, packet ends on the status byte
      pkt_q.delete();
      put_word(16'h0000);
      put_word(16'h818f);
      send_packet(-1);
      // ends on its first byte
      pkt_q.delete();
      put_byte(8'h00);
      send_packet(-1);
      // no answers, root question name, one byte after the status
      pkt_q.delete();
      put_header(16'h0000, 16'h8180, 16'd0);
      put_byte(8'h00);
      put_word(16'd1);
      put_word(16'd1);
      put_byte(8'hab);
      send_packet(-1);
      // pointer after a label, match with empty RDATA
      pkt_q.delete();
      put_header(16'h0000, 16'h8180, 16'd1);
      put_byte(8'h01);
      put_byte(8'h61);
      put_word(16'hc00c);
      put_word(16'd1);
      put_word(16'd1);
      put_word(16'hc00c);
      put_word(16'd1);
      put_word(16'd1);
      put_random(4);
      put_word(16'd0);
      send_packet(-1);
      // first record skipped, second one emitted
      pkt_q.delete();
      put_header(16'h0000, 16'h8180, 16'd2);
      put_byte(8'h00);
      put_word(16'd28);
      put_word(16'd1);
      put_byte(8'h00);
      put_word(16'd1);
      put_word(16'd1);
      put_random(4);
      put_word(16'd1);
      put_byte(8'h55);
      put_word(16'hc00c);
      put_word(16'd28);
      put_word(16'd1);
      put_random(4);
      put_word(16'd2);
      put_word(16'h00ff);
      send_packet(-1);
      drain_block();

      // Random responses under several ID settings
      write_expected_id(16'hffff);
      run_random(350, 1'b1, 1'b0);
      drain_block();
      write_expected_id(16'($urandom));
      run_random(350, 1'b1, 1'b1);
      drain_block();
      write_expected_id(16'h0000);
      run_random(300, 1'b0, 1'b0);
      drain_block();
      repeat (8) @(negedge clock);

      if (mirror.errors == 0 && mirror.pending() == 0)
         $display("dns_response_answer_extractor_unit_tb: done, clean");
      else
         $display("dns_response_answer_extractor_unit_tb: done, errors");
      $finish;
   end

endmodule
